[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the request framer.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

[rtl/mrf_pkg.sv]
// Package of the request framer: command and result types, protocol constants
// and the CRC-16 byte update. It depends on nothing else.
package mrf_pkg;

    localparam int STEP_W = 4;

    localparam logic [15:0] BASE_HOLD   = 16'd40000;
    localparam logic [15:0] BASE_INPUT  = 16'd30000;
    localparam logic [15:0] BASE_DISC   = 16'd10000;
    localparam logic [15:0] REGION_SPAN = 16'd10000;
    localparam logic [16:0] HOLD_END    = 17'd50000;

    localparam logic [10:0] LIM_WRITE_REGS  = 11'd123;
    localparam logic [10:0] LIM_READ_REGS   = 11'd125;
    localparam logic [10:0] LIM_WRITE_COILS = 11'd1976;
    localparam logic [10:0] LIM_READ_BITS   = 11'd2000;

    localparam logic [7:0] FN_READ_COILS    = 8'h01;
    localparam logic [7:0] FN_READ_DISC     = 8'h02;
    localparam logic [7:0] FN_READ_HOLD     = 8'h03;
    localparam logic [7:0] FN_READ_INPUT    = 8'h04;
    localparam logic [7:0] FN_WRITE_COILS   = 8'h0F;
    localparam logic [7:0] FN_WRITE_REGS    = 8'h10;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_COUNT       = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED  = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        CMD_STATUS,
        CMD_HEADER,
        CMD_PAYLOAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  status;
        logic        close;
        logic        wr;
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] start;
        logic [10:0] count;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_of_frame;
        logic [1:0] status;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data_in);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/modbus_rtu_request_framer_top.sv]
// Top level of the Modbus RTU request framer: front end, command queue,
// back end and result queue. Depends on mrf_pkg, mrf_fifo, mrf_front, mrf_back.
//
// Items are taken one per cycle while the command queue (CMD_DEPTH entries)
// has room; the front end classifies each item in the cycle of its transfer.
// The back end emits one result per cycle, while a command waits and the
// result queue (RES_DEPTH entries) has room: 8 results for a read header, 9
// for a write header without payload, 7 for one that waits for payload, 1 or
// 3 for a payload byte (3 when it closes the frame) and 1 for a status. An
// item passes the command queue and then the result queue to reach the ports.
`include "assert_macros.svh"

module modbus_rtu_request_framer_top #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  slave_address,
    input  logic        write_request,
    input  logic [15:0] element_address,
    input  logic [10:0] element_count,
    input  logic [7:0]  payload_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_byte,
    output logic        last_of_frame,
    output logic [1:0]  status
);
    mrf_pkg::cmd_t    cmd_in;
    mrf_pkg::cmd_t    cmd_head;
    mrf_pkg::result_t res_in;
    mrf_pkg::result_t res_head;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_empty;
    logic             res_push;
    logic             res_full;

    assign full = cmd_full;

    mrf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .mode            (mode),
        .slave_address   (slave_address),
        .write_request   (write_request),
        .element_address (element_address),
        .element_count   (element_count),
        .payload_byte    (payload_byte),
        .cmd_full        (cmd_full),
        .cmd_push        (cmd_push),
        .cmd             (cmd_in)
    );

    mrf_fifo #(
        .WIDTH ($bits(mrf_pkg::cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmd_empty)
    );

    mrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    mrf_fifo #(
        .WIDTH ($bits(mrf_pkg::result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign frame_byte    = res_head.frame_byte;
    assign last_of_frame = res_head.last_of_frame;
    assign status        = res_head.status;

    `ASSERT_IMPL(a_res_no_overflow, res_push, !res_full)
    `ASSERT_IMPL(a_cmd_pop_valid, cmd_pop, !cmd_empty)
    `ASSERT_IMPL(a_status_is_last, !empty && status != mrf_pkg::ST_OK, last_of_frame && frame_byte == 8'd0)
    `ASSERT_NEXT(a_push_not_empty, cmd_push, !cmd_empty)

endmodule

[rtl/mrf_fifo.sv]
// Small first-in first-out queue of flat words, used for commands and results.
// Depends on no package.
module mrf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/mrf_front.sv]
// Front end of the request framer: classifies header and payload items,
// tracks the expected payload, and issues commands. Depends on mrf_pkg.
module mrf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           mode,
    input  logic [7:0]     slave_address,
    input  logic           write_request,
    input  logic [15:0]    element_address,
    input  logic [10:0]    element_count,
    input  logic [7:0]     payload_byte,
    input  logic           cmd_full,
    output logic           cmd_push,
    output mrf_pkg::cmd_t  cmd
);
    logic        awaiting_reg, awaiting_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic        ok;
    logic [7:0]  func;
    logic [15:0] base;
    logic [10:0] limit;
    logic [7:0]  nbytes;
    logic [11:0] coil_sum;
    logic [16:0] addr_ext;

    assign cmd_push = push && !cmd_full;
    assign addr_ext = {1'b0, element_address};
    assign coil_sum = {1'b0, element_count} + 12'd7;

    always_comb
    begin
        ok    = 1'b1;
        func  = mrf_pkg::FN_READ_COILS;
        base  = '0;
        limit = mrf_pkg::LIM_READ_BITS;
        if (element_address >= mrf_pkg::BASE_HOLD && addr_ext < mrf_pkg::HOLD_END)
        begin
            base  = mrf_pkg::BASE_HOLD;
            func  = write_request ? mrf_pkg::FN_WRITE_REGS : mrf_pkg::FN_READ_HOLD;
            limit = write_request ? mrf_pkg::LIM_WRITE_REGS : mrf_pkg::LIM_READ_REGS;
        end
        else if (element_address >= mrf_pkg::BASE_INPUT
                 && element_address < mrf_pkg::BASE_INPUT + mrf_pkg::REGION_SPAN)
        begin
            base  = mrf_pkg::BASE_INPUT;
            ok    = !write_request;
            func  = mrf_pkg::FN_READ_INPUT;
            limit = mrf_pkg::LIM_READ_REGS;
        end
        else if (element_address >= mrf_pkg::BASE_DISC
                 && element_address < mrf_pkg::BASE_DISC + mrf_pkg::REGION_SPAN)
        begin
            base  = mrf_pkg::BASE_DISC;
            ok    = !write_request;
            func  = mrf_pkg::FN_READ_DISC;
            limit = mrf_pkg::LIM_READ_BITS;
        end
        else if (element_address < mrf_pkg::REGION_SPAN)
        begin
            func  = write_request ? mrf_pkg::FN_WRITE_COILS : mrf_pkg::FN_READ_COILS;
            limit = write_request ? mrf_pkg::LIM_WRITE_COILS : mrf_pkg::LIM_READ_BITS;
        end
        else
        begin
            ok = 1'b0;
        end

        if (func == mrf_pkg::FN_WRITE_REGS)
        begin
            nbytes = {element_count[6:0], 1'b0};
        end
        else
        begin
            nbytes = coil_sum[10:3];
        end

        cmd            = '0;
        cmd.kind       = mrf_pkg::CMD_STATUS;
        cmd.status     = mrf_pkg::ST_OK;
        cmd.slave      = slave_address;
        cmd.func       = func;
        cmd.start      = element_address - base;
        cmd.count      = element_count;
        cmd.wr         = write_request;
        awaiting_next  = 1'b0;
        remaining_next = '0;

        if (mode)
        begin
            if (!awaiting_reg || remaining_reg == '0)
            begin
                cmd.status = mrf_pkg::ST_UNEXPECTED;
            end
            else
            begin
                cmd.kind       = mrf_pkg::CMD_PAYLOAD;
                cmd.data       = payload_byte;
                cmd.close      = (remaining_reg == 8'd1);
                remaining_next = remaining_reg - 1'b1;
                awaiting_next  = (remaining_reg != 8'd1);
            end
        end
        else if (!ok)
        begin
            cmd.status = mrf_pkg::ST_UNSUPPORTED;
        end
        else if (element_count > limit)
        begin
            cmd.status = mrf_pkg::ST_COUNT;
        end
        else
        begin
            cmd.kind  = mrf_pkg::CMD_HEADER;
            cmd.data  = nbytes;
            cmd.close = !write_request || (nbytes == '0);
            if (write_request && nbytes != '0)
            begin
                awaiting_next  = 1'b1;
                remaining_next = nbytes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b0;
            remaining_reg <= '0;
        end
        else if (cmd_push)
        begin
            awaiting_reg  <= awaiting_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

[rtl/mrf_back.sv]
// Back end of the request framer: keeps a running CRC-16 and steps through
// each command one byte per cycle while res_full is low. Depends on mrf_pkg.
module mrf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mrf_pkg::cmd_t    cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output mrf_pkg::result_t res
);
    logic [mrf_pkg::STEP_W-1:0] step_reg, step_next;
    logic [mrf_pkg::STEP_W-1:0] ndata;
    logic [15:0]                crc_reg, crc_next;
    logic [15:0]                crc_base;
    logic [7:0]                 data_byte;
    logic                       go;
    logic                       done;

    always_comb
    begin
        go        = !cmd_empty && !res_full;
        ndata     = (cmd.kind == mrf_pkg::CMD_HEADER) ?
                    (cmd.wr ? mrf_pkg::STEP_W'(7) : mrf_pkg::STEP_W'(6)) :
                    mrf_pkg::STEP_W'(1);
        crc_base  = (cmd.kind == mrf_pkg::CMD_HEADER && step_reg == '0) ?
                    mrf_pkg::CRC_INIT : crc_reg;

        case (step_reg)
            mrf_pkg::STEP_W'(0): data_byte = cmd.slave;
            mrf_pkg::STEP_W'(1): data_byte = cmd.func;
            mrf_pkg::STEP_W'(2): data_byte = cmd.start[15:8];
            mrf_pkg::STEP_W'(3): data_byte = cmd.start[7:0];
            mrf_pkg::STEP_W'(4): data_byte = {5'b0, cmd.count[10:8]};
            mrf_pkg::STEP_W'(5): data_byte = cmd.count[7:0];
            default:             data_byte = cmd.data;
        endcase
        if (cmd.kind == mrf_pkg::CMD_PAYLOAD)
        begin
            data_byte = cmd.data;
        end

        res       = '0;
        crc_next  = crc_reg;
        done      = 1'b0;
        case (cmd.kind)
            mrf_pkg::CMD_STATUS:
            begin
                res.last_of_frame = 1'b1;
                res.status        = cmd.status;
                done              = 1'b1;
            end
            default:
            begin
                if (step_reg < ndata)
                begin
                    res.frame_byte = data_byte;
                    crc_next       = mrf_pkg::crc_byte(crc_base, data_byte);
                    done           = !cmd.close && (step_reg == ndata - 1'b1);
                end
                else if (step_reg == ndata)
                begin
                    res.frame_byte = crc_reg[7:0];
                end
                else
                begin
                    res.frame_byte    = crc_reg[15:8];
                    res.last_of_frame = 1'b1;
                    crc_next          = mrf_pkg::CRC_INIT;
                    done              = 1'b1;
                end
            end
        endcase

        res_push  = go;
        cmd_pop   = go && done;
        step_next = step_reg;
        if (go)
        begin
            step_next = done ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            crc_reg  <= mrf_pkg::CRC_INIT;
        end
        else
        begin
            step_reg <= step_next;
            if (go)
            begin
                crc_reg <= crc_next;
            end
        end
    end

endmodule
